/* hw/rtl/dlet_pkg.sv */
// shared types and constants of the deadline event table
package dlet_pkg;

   // table geometry
   localparam int SlotCount = 64;
   localparam int IdxWidth  = $clog2(SlotCount);
   localparam logic [IdxWidth-1:0] SlotLast = IdxWidth'(SlotCount - 1);

   // fixed field widths
   localparam int KindWidth     = 2;
   localparam int TargetWidth   = 8;
   localparam int OptionWidth   = 8;
   localparam int TimeWidth     = 32;
   localparam int SlotNumWidth  = 6;
   localparam int StageWidth    = 8;

   // item opcodes
   typedef enum logic {
      OP_SCHEDULE = 1'b0,
      OP_TICK     = 1'b1
   } op_type;

   // event kinds
   typedef enum logic [KindWidth-1:0] {
      KIND_RELAY = 2'd0,
      KIND_LIGHT = 2'd1,
      KIND_SOUND = 2'd2,
      KIND_STAGE = 2'd3
   } kind_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIND,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // one stored event
   typedef struct packed {
      logic [KindWidth-1:0]   kind;
      logic [TargetWidth-1:0] target;
      logic [OptionWidth-1:0] option;
      logic [TimeWidth-1:0]   deadline;
   } slot_entry_type;

   localparam int EntryWidth = $bits(slot_entry_type);

   // accepted input item
   typedef struct packed {
      slot_entry_type         entry;
      logic [TimeWidth-1:0]   now_time;
   } item_type;

   // one result beat
   typedef struct packed {
      logic [KindWidth-1:0]    kind;
      logic [TargetWidth-1:0]  target;
      logic [OptionWidth-1:0]  option;
      logic [SlotNumWidth-1:0] slot;
      logic [StageWidth-1:0]   stage;
      logic                    last;
   } result_type;

endpackage

/* hw/rtl/dlet_slot_ram.sv */
// simple dual-port event payload memory (one write port, one read port) with registered read data
module dlet_slot_ram #(
   parameter int Depth     = 64,
   parameter int Width     = 50,
   parameter int AddrWidth = $clog2(Depth)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/deadline_event_table.sv */
// deadline event table: slot store, schedule search and tick scan
//
// Events live in a SlotCount-entry payload memory with registered read data;
// active marks sit in flip-flops and are cleared by reset. A schedule item
// walks the active marks one slot per cycle from slot 0 to the lowest free
// slot (slot 0 when all are busy), and busy stays high until that slot is
// written. A tick item reads every slot in index order, one memory read per
// cycle, and keeps busy high until the scan has been flushed.
// Each due event leaves as one rsp_strobe beat of a single cycle; the results
// cannot be stalled. A fired event is held back one beat until the next due
// event or the end of the scan is known, so that rsp_last_of_tick marks the
// final beat of the tick. A tick with nothing due gives no beat.
module deadline_event_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [1:0]  req_effect_kind,
   input  logic [7:0]  req_target_id,
   input  logic [7:0]  req_option_code,
   input  logic [31:0] req_deadline,
   input  logic [31:0] req_now_time,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_fired_kind,
   output logic [7:0]  rsp_fired_target,
   output logic [7:0]  rsp_fired_option,
   output logic [5:0]  rsp_fired_slot,
   output logic [7:0]  rsp_stage_value,
   output logic        rsp_last_of_tick
);

   dlet_pkg::state_type                     state_ff, state_in;
   dlet_pkg::item_type                      item_ff;
   logic [dlet_pkg::SlotCount-1:0]          active_ff, active_in;
   logic [dlet_pkg::IdxWidth-1:0]           find_idx_ff, find_idx_in;
   logic [dlet_pkg::IdxWidth-1:0]           rd_idx_ff, rd_idx_in;
   logic                                    rd_done_ff, rd_done_in;
   logic                                    chk_valid_ff, chk_valid_in;
   logic [dlet_pkg::IdxWidth-1:0]           chk_idx_ff, chk_idx_in;
   logic [dlet_pkg::StageWidth-1:0]         stage_ff, stage_in;
   logic                                    pend_valid_ff, pend_valid_in;
   dlet_pkg::result_type                    pend_ff, pend_in;
   logic                                    rsp_strobe_ff, rsp_strobe_in;
   dlet_pkg::result_type                    rsp_ff, rsp_in;
   logic                                    accept;
   logic                                    ram_we;
   logic [dlet_pkg::IdxWidth-1:0]           ram_wr_addr;
   logic                                    ram_rd_en;
   logic [dlet_pkg::EntryWidth-1:0]         ram_rd_bits;
   dlet_pkg::slot_entry_type                rd_entry;

   assign busy     = (state_ff != dlet_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign rd_entry = dlet_pkg::slot_entry_type'(ram_rd_bits);

   // payload memory
   dlet_slot_ram #(
      .Depth     (dlet_pkg::SlotCount),
      .Width     (dlet_pkg::EntryWidth),
      .AddrWidth (dlet_pkg::IdxWidth)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (item_ff.entry),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_bits)
   );

   // next state, memory control and result beats
   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      find_idx_in   = find_idx_ff;
      rd_idx_in     = rd_idx_ff;
      rd_done_in    = rd_done_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      stage_in      = stage_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = find_idx_ff;
      ram_rd_en     = 1'b0;
      case (state_ff)
         dlet_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_op == dlet_pkg::OP_TICK) begin
                  state_in      = dlet_pkg::ST_SCAN;
                  rd_idx_in     = '0;
                  rd_done_in    = 1'b0;
                  pend_valid_in = 1'b0;
               end else begin
                  state_in    = dlet_pkg::ST_FIND;
                  find_idx_in = '0;
               end
            end
         end
         dlet_pkg::ST_FIND: begin
            // lowest free slot, else overwrite slot 0
            if (!active_ff[find_idx_ff]) begin
               ram_we                 = 1'b1;
               ram_wr_addr            = find_idx_ff;
               active_in[find_idx_ff] = 1'b1;
               state_in               = dlet_pkg::ST_IDLE;
            end else if (find_idx_ff == dlet_pkg::SlotLast) begin
               ram_we       = 1'b1;
               ram_wr_addr  = '0;
               active_in[0] = 1'b1;
               state_in     = dlet_pkg::ST_IDLE;
            end else begin
               find_idx_in = find_idx_ff + 1'b1;
            end
         end
         dlet_pkg::ST_SCAN: begin
            // issue one read per cycle
            if (!rd_done_ff) begin
               ram_rd_en    = 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_idx_ff;
               if (rd_idx_ff == dlet_pkg::SlotLast) begin
                  rd_done_in = 1'b1;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
            // check the slot read last cycle
            if (chk_valid_ff && active_ff[chk_idx_ff] &&
                !(item_ff.now_time < rd_entry.deadline)) begin
               active_in[chk_idx_ff] = 1'b0;
               if (rd_entry.kind == dlet_pkg::KIND_STAGE) begin
                  stage_in = stage_ff + 1'b1;
               end
               if (pend_valid_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = pend_ff;
                  rsp_in.last   = 1'b0;
               end
               pend_in.kind   = rd_entry.kind;
               pend_in.target = rd_entry.target;
               pend_in.option = rd_entry.option;
               pend_in.slot   = dlet_pkg::SlotNumWidth'(chk_idx_ff);
               pend_in.stage  = stage_in;
               pend_in.last   = 1'b0;
               pend_valid_in  = 1'b1;
            end
            if (chk_valid_ff && (chk_idx_ff == dlet_pkg::SlotLast)) begin
               state_in = dlet_pkg::ST_FLUSH;
            end
         end
         dlet_pkg::ST_FLUSH: begin
            // held beat is the last of the tick
            if (pend_valid_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = dlet_pkg::ST_IDLE;
         end
         default: begin
            state_in = dlet_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dlet_pkg::ST_IDLE;
         active_ff     <= '0;
         stage_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
         rd_done_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         stage_ff      <= stage_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         chk_valid_ff  <= chk_valid_in;
         rd_done_ff    <= rd_done_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      find_idx_ff <= find_idx_in;
      rd_idx_ff   <= rd_idx_in;
      chk_idx_ff  <= chk_idx_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      if (accept) begin
         item_ff.entry.kind     <= req_effect_kind;
         item_ff.entry.target   <= req_target_id;
         item_ff.entry.option   <= req_option_code;
         item_ff.entry.deadline <= req_deadline;
         item_ff.now_time       <= req_now_time;
      end
   end

   // result ports
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_fired_kind   = rsp_ff.kind;
   assign rsp_fired_target = rsp_ff.target;
   assign rsp_fired_option = rsp_ff.option;
   assign rsp_fired_slot   = rsp_ff.slot;
   assign rsp_stage_value  = rsp_ff.stage;
   assign rsp_last_of_tick = rsp_ff.last;

endmodule

/* bench/testbench.sv */
// self-checking testbench for the deadline event table
`timescale 1ns / 1ps

module testbench;
   import dlet_pkg::*;

   localparam int RandomItems   = 500;
   localparam int MaxItems      = 3000;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = SlotCount + 16;

   // tracks the slot table and predicts the fired-event beats
   class event_firing_board;
      bit          slot_busy [SlotCount];
      kind_type    slot_kind [SlotCount];
      logic [7:0]  slot_target [SlotCount];
      logic [7:0]  slot_option [SlotCount];
      logic [31:0] slot_deadline [SlotCount];
      logic [7:0]  stage_count;
      bit          stage_wrapped;
      result_type  due_events [$];
      int          mismatches;

      function new();
         foreach (slot_busy[i]) slot_busy[i] = 1'b0;
         stage_count   = '0;
         stage_wrapped = 1'b0;
         mismatches    = 0;
      endfunction

      // update the table for one accepted item, queue the beats it fires
      function void note_item(op_type op, kind_type kind, logic [7:0] target,
                              logic [7:0] option, logic [31:0] deadline,
                              logic [31:0] now);
         int         slot;
         int         fired;
         result_type beat;
         slot  = 0;
         fired = 0;
         if (op == OP_SCHEDULE) begin
            // lowest free slot, slot 0 when the table is full
            for (int i = SlotCount - 1; i >= 0; i--) begin
               if (!slot_busy[i]) slot = i;
            end
            slot_busy[slot]     = 1'b1;
            slot_kind[slot]     = kind;
            slot_target[slot]   = target;
            slot_option[slot]   = option;
            slot_deadline[slot] = deadline;
            return;
         end
         // tick: scan in index order, fire and free every due slot
         for (int i = 0; i < SlotCount; i++) begin
            if (slot_busy[i] && slot_deadline[i] <= now) begin
               if (slot_kind[i] == KIND_STAGE) begin
                  if (stage_count == 8'hFF) stage_wrapped = 1'b1;
                  stage_count = stage_count + 8'd1;
               end
               beat.kind   = slot_kind[i];
               beat.target = slot_target[i];
               beat.option = slot_option[i];
               beat.slot   = SlotNumWidth'(i);
               beat.stage  = stage_count;
               beat.last   = 1'b0;
               due_events.push_back(beat);
               slot_busy[i] = 1'b0;
               fired++;
            end
         end
         if (fired > 0) due_events[due_events.size() - 1].last = 1'b1;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
         end
      endfunction

      // compare one result beat with the oldest predicted beat
      function void check_fired(result_type got);
         result_type want;
         if (due_events.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat, expected none, actual slot %0d",
                     $time, got.slot);
            return;
         end
         want = due_events.pop_front();
         compare_field("fired_kind", 32'(want.kind), 32'(got.kind));
         compare_field("fired_target", 32'(want.target), 32'(got.target));
         compare_field("fired_option", 32'(want.option), 32'(got.option));
         compare_field("fired_slot", 32'(want.slot), 32'(got.slot));
         compare_field("stage_value", 32'(want.stage), 32'(got.stage));
         compare_field("last_of_tick", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_op = OP_SCHEDULE;
   logic [1:0]  req_effect_kind = '0;
   logic [7:0]  req_target_id = '0;
   logic [7:0]  req_option_code = '0;
   logic [31:0] req_deadline = '0;
   logic [31:0] req_now_time = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_fired_kind;
   logic [7:0]  rsp_fired_target;
   logic [7:0]  rsp_fired_option;
   logic [5:0]  rsp_fired_slot;
   logic [7:0]  rsp_stage_value;
   logic        rsp_last_of_tick;

   event_firing_board board = new();
   result_type        seen_beat;
   int                quiet_cycles = 0;
   int                items_sent = 0;
   int                directed_end = 0;
   logic [31:0]       time_base;

   deadline_event_table u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_effect_kind  (req_effect_kind),
      .req_target_id    (req_target_id),
      .req_option_code  (req_option_code),
      .req_deadline     (req_deadline),
      .req_now_time     (req_now_time),
      .rsp_strobe       (rsp_strobe),
      .rsp_fired_kind   (rsp_fired_kind),
      .rsp_fired_target (rsp_fired_target),
      .rsp_fired_option (rsp_fired_option),
      .rsp_fired_slot   (rsp_fired_slot),
      .rsp_stage_value  (rsp_stage_value),
      .rsp_last_of_tick (rsp_last_of_tick)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sample both channels at the edge, plus the stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            seen_beat = {rsp_fired_kind, rsp_fired_target, rsp_fired_option,
                         rsp_fired_slot, rsp_stage_value, rsp_last_of_tick};
            board.check_fired(seen_beat);
         end
         if (start && !busy)
            board.note_item(op_type'(req_op), kind_type'(req_effect_kind),
                            req_target_id, req_option_code, req_deadline,
                            req_now_time);
         if (rsp_strobe || (start && !busy)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 8) return 0;
      if (roll < 17) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // stage events dominate so that the stage counter wraps
   function automatic kind_type pick_kind();
      if ($urandom_range(0, 3) != 0) return KIND_STAGE;
      return kind_type'($urandom_range(0, 2));
   endfunction

   // present one item, hold it until accepted, then for a nonzero gap drop start and wait out the gap
   task automatic send_item(op_type op, kind_type kind, logic [7:0] target,
                            logic [7:0] option, logic [31:0] deadline,
                            logic [31:0] now, int gap);
      req_op          <= op;
      req_effect_kind <= kind;
      req_target_id   <= target;
      req_option_code <= option;
      req_deadline    <= deadline;
      req_now_time    <= now;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic schedule_event(logic [31:0] deadline, int gap);
      send_item(OP_SCHEDULE, pick_kind(), 8'($urandom), 8'($urandom), deadline,
                $urandom, gap);
   endtask

   task automatic tick_at(logic [31:0] now, int gap);
      send_item(OP_TICK, kind_type'($urandom_range(0, 3)), 8'($urandom),
                8'($urandom), $urandom, now, gap);
   endtask

   // a batch of events near the time base, then ticks that sweep past them
   task automatic run_round();
      int n;
      int ticks;
      int span;
      n     = $urandom_range(1, 12);
      ticks = $urandom_range(1, 3);
      span  = $urandom_range(16, 1000);
      repeat (n) schedule_event(time_base + $urandom_range(0, span), pick_gap());
      for (int j = 1; j <= ticks; j++)
         tick_at(time_base + (span * j) / ticks, pick_gap());
      time_base = time_base + span + 1;
   endtask

   // fill the table past full without idling, then fire everything
   task automatic run_burst();
      repeat (SlotCount + $urandom_range(1, 3)) schedule_event($urandom, 0);
      tick_at(32'hFFFF_FFFF, pick_gap());
   endtask

   // fully random item
   task automatic run_noise();
      logic [31:0] now;
      now = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
      send_item(op_type'($urandom_range(0, 1)), kind_type'($urandom_range(0, 3)),
                8'($urandom), 8'($urandom), $urandom, now, pick_gap());
   endtask

   initial begin
      int mode;
      time_base = $urandom_range(0, 32'h7FFF_FFFF);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, field extremes, equal deadline, unsigned compare
      tick_at(32'd0, pick_gap());
      send_item(OP_SCHEDULE, KIND_RELAY, 8'h00, 8'h00, 32'd0, $urandom, pick_gap());
      send_item(OP_SCHEDULE, KIND_LIGHT, 8'hFF, 8'hFF, 32'hFFFF_FFFF, $urandom,
                pick_gap());
      send_item(OP_SCHEDULE, KIND_SOUND, 8'hAA, 8'h55, 32'd100, $urandom, pick_gap());
      send_item(OP_SCHEDULE, KIND_STAGE, 8'h55, 8'hAA, 32'd100, $urandom, pick_gap());
      tick_at(32'd99, pick_gap());
      tick_at(32'd100, pick_gap());
      send_item(OP_SCHEDULE, KIND_STAGE, 8'h01, 8'h80, 32'd7, 32'hFFFF_FFFF,
                pick_gap());
      send_item(OP_SCHEDULE, KIND_RELAY, 8'h7F, 8'hFE, 32'h8000_0000, 32'd0,
                pick_gap());
      tick_at(32'h7FFF_FFFF, pick_gap());
      tick_at(32'hFFFF_FFFE, pick_gap());
      tick_at(32'hFFFF_FFFF, pick_gap());
      tick_at(32'd0, pick_gap());
      directed_end = items_sent;

      // random mix of rounds, full-table bursts and noise
      while ((items_sent < directed_end + RandomItems || !board.stage_wrapped)
             && items_sent < MaxItems) begin
         mode = $urandom_range(0, 9);
         if (mode < 6) run_round();
         else if (mode == 6) run_burst();
         else run_noise();
      end
      start <= 1'b0;

      // drain outstanding beats, then watch for stray ones
      while (board.due_events.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (board.mismatches == 0 && board.due_events.size() == 0) begin
         $display("end of test: clean");
      end else begin
         if (board.due_events.size() != 0)
            $display("%0t: %0d predicted beats never arrived", $time,
                     board.due_events.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/dlet_pkg.sv
hw/rtl/dlet_slot_ram.sv
hw/rtl/deadline_event_table.sv
bench/testbench.sv
